[rtl/mmbb_pkg.sv]
// ----------------------------------------------------------------------------
// mmbb_pkg
// Shared types, constants and helpers of the mask bounding-box block.
// ----------------------------------------------------------------------------
package mmbb_pkg;

	localparam int MAX_DIMENSION = 4096;
	localparam int SAMPLE_STRIDE = 2;

	localparam int DIM_W  = $clog2(MAX_DIMENSION) + 1;
	localparam int POS_W  = DIM_W - 1;
	localparam int CNT_W  = 23;
	localparam int PIX_W  = 8;
	localparam int MRG_W  = 8;
	localparam int IDX_W  = 2;

	localparam logic [PIX_W-1:0] MOTION_LEVEL = 8'd255;
	localparam logic [CNT_W-1:0] COUNT_MAX    = {CNT_W{1'b1}};

	localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = DIM_W'(640);
	localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = DIM_W'(480);
	localparam logic [MRG_W-1:0] RST_BOX_MARGIN   = MRG_W'(10);

	typedef logic [DIM_W-1:0] dim_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [MRG_W-1:0] mrg_t;
	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_BOX_MARGIN   = 2'd2
	} cfg_idx_t;

	// frame totals handed from the accumulator to the padding stage
	typedef struct packed {
		cnt_t count;
		dim_t least_col;
		pos_t great_col;
		dim_t least_row;
		pos_t great_row;
		mrg_t margin;
		pos_t last_col;
		pos_t last_row;
	} summary_t;

	function automatic dim_t eff_size(input dim_t v);
		dim_t r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIMENSION)) begin
			r = DIM_W'(MAX_DIMENSION);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

[rtl/mmbb_if.sv]
// ----------------------------------------------------------------------------
// mmbb interfaces
// Valid/ready channels for mask pixels, frame results and register writes.
// ----------------------------------------------------------------------------
interface mmbb_pix_if;
	import mmbb_pkg::*;
	logic valid;
	logic ready;
	pix_t mask_value;
	logic frame_end;
	modport source (output valid, output mask_value, output frame_end, input ready);
	modport sink   (input valid, input mask_value, input frame_end, output ready);
endinterface

interface mmbb_res_if;
	import mmbb_pkg::*;
	logic valid;
	logic ready;
	cnt_t change_count;
	logic motion_found;
	pos_t box_left;
	pos_t box_top;
	pos_t box_right;
	pos_t box_bottom;
	modport source (output valid, output change_count, output motion_found,
		output box_left, output box_top, output box_right, output box_bottom,
		input ready);
	modport sink   (input valid, input change_count, input motion_found,
		input box_left, input box_top, input box_right, input box_bottom,
		output ready);
endinterface

interface mmbb_cfg_if;
	import mmbb_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] index;
	dim_t             data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/motion_mask_bounding_box.sv]
// ----------------------------------------------------------------------------
// motion_mask_bounding_box
// Counts sampled motion pixels per frame and reports a padded bounding box.
//
//   channel  dir  beat
//   pix_in   in   mask_value, frame_end
//   res_out  out  change_count, motion_found, box_left/top/right/bottom
//   cfg      in   index, data (frame_width, frame_height, box_margin)
//
// One pixel beat per cycle; the accumulator updates in the cycle of the beat.
// A frame_end result is registered in sum_s1, then in the res_out register.
// pix_in stalls only when a summary waits and res_out is held full.
// cfg is always ready. Reset restores the default sizes and an empty frame.
// ----------------------------------------------------------------------------
module motion_mask_bounding_box (
	input  logic       clk,
	input  logic       arst_n,
	mmbb_pix_if.sink   pix_in,
	mmbb_res_if.source res_out,
	mmbb_cfg_if.sink   cfg
);
	import mmbb_pkg::*;

	dim_t frame_width_q, frame_height_q;
	mrg_t box_margin_q;
	dim_t eff_w, eff_h;

	logic     in_fire;
	logic     sum_valid_s1, sum_ready;
	summary_t sum_s1;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			box_margin_q   <= RST_BOX_MARGIN;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				REG_FRAME_WIDTH:  frame_width_q  <= cfg.data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg.data;
				REG_BOX_MARGIN:   box_margin_q   <= cfg.data[MRG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign eff_w = eff_size(frame_width_q);
	assign eff_h = eff_size(frame_height_q);

	assign pix_in.ready = !sum_valid_s1 || sum_ready;
	assign in_fire      = pix_in.valid && pix_in.ready;

	mmbb_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_fire      (in_fire),
		.mask_value   (pix_in.mask_value),
		.frame_end    (pix_in.frame_end),
		.eff_w        (eff_w),
		.eff_h        (eff_h),
		.margin       (box_margin_q),
		.sum_ready    (sum_ready),
		.sum_valid_s1 (sum_valid_s1),
		.sum_s1       (sum_s1)
	);

	mmbb_pad u_pad (
		.clk          (clk),
		.arst_n       (arst_n),
		.sum_valid_s1 (sum_valid_s1),
		.sum_s1       (sum_s1),
		.sum_ready    (sum_ready),
		.res          (res_out)
	);

	a_end_makes_summary: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && pix_in.frame_end |=> sum_valid_s1)
		else $error("frame end beat did not produce a summary");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid_s1 && !sum_ready |-> !pix_in.ready)
		else $error("pixel beat taken while summary is blocked");

	a_found_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid |-> (res_out.motion_found == (res_out.change_count != '0)))
		else $error("motion_found disagrees with change_count");

	a_empty_box: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && !res_out.motion_found |->
		res_out.box_left == '0 && res_out.box_top == '0 &&
		res_out.box_right == '0 && res_out.box_bottom == '0)
		else $error("box fields set without motion");

endmodule

[rtl/mmbb_accum.sv]
// ----------------------------------------------------------------------------
// mmbb_accum
// Raster position tracking, hit count and box extremes; frame summary stage.
// ----------------------------------------------------------------------------
module mmbb_accum (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  mmbb_pkg::pix_t    mask_value,
	input  logic              frame_end,
	input  mmbb_pkg::dim_t    eff_w,
	input  mmbb_pkg::dim_t    eff_h,
	input  mmbb_pkg::mrg_t    margin,
	input  logic              sum_ready,
	output logic              sum_valid_s1,
	output mmbb_pkg::summary_t sum_s1
);
	import mmbb_pkg::*;

	pos_t col_q, row_q;
	cnt_t cnt_q;
	dim_t lc_q, lr_q;
	pos_t gc_q, gr_q;

	logic hit;
	cnt_t cnt_nx;
	dim_t lc_nx, lr_nx;
	pos_t gc_nx, gr_nx;
	dim_t col_inc, row_inc;

	assign hit = ((col_q % POS_W'(SAMPLE_STRIDE)) == '0)
		&& ((row_q % POS_W'(SAMPLE_STRIDE)) == '0)
		&& (mask_value == MOTION_LEVEL);

	assign cnt_nx = (hit && cnt_q != COUNT_MAX) ? cnt_q + CNT_W'(1) : cnt_q;
	assign lc_nx  = (hit && {1'b0, col_q} < lc_q) ? {1'b0, col_q} : lc_q;
	assign lr_nx  = (hit && {1'b0, row_q} < lr_q) ? {1'b0, row_q} : lr_q;
	assign gc_nx  = (hit && col_q > gc_q) ? col_q : gc_q;
	assign gr_nx  = (hit && row_q > gr_q) ? row_q : gr_q;

	assign col_inc = {1'b0, col_q} + DIM_W'(1);
	assign row_inc = {1'b0, row_q} + DIM_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cnt_q <= '0;
			lc_q  <= RST_FRAME_WIDTH;
			lr_q  <= RST_FRAME_HEIGHT;
			gc_q  <= '0;
			gr_q  <= '0;
		end else if (in_fire) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
				cnt_q <= '0;
				lc_q  <= eff_w;
				lr_q  <= eff_h;
				gc_q  <= '0;
				gr_q  <= '0;
			end else begin
				cnt_q <= cnt_nx;
				lc_q  <= lc_nx;
				lr_q  <= lr_nx;
				gc_q  <= gc_nx;
				gr_q  <= gr_nx;
				if (col_inc >= eff_w) begin
					col_q <= '0;
					row_q <= (row_inc >= eff_h) ? '0 : row_inc[POS_W-1:0];
				end else begin
					col_q <= col_inc[POS_W-1:0];
				end
			end
		end
	end

	// hold the summary until the padding stage takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_valid_s1 <= 1'b0;
		end else if (in_fire && frame_end) begin
			sum_valid_s1 <= 1'b1;
		end else if (sum_ready) begin
			sum_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && frame_end) begin
			sum_s1.count     <= cnt_nx;
			sum_s1.least_col <= lc_nx;
			sum_s1.great_col <= gc_nx;
			sum_s1.least_row <= lr_nx;
			sum_s1.great_row <= gr_nx;
			sum_s1.margin    <= margin;
			sum_s1.last_col  <= POS_W'(eff_w - DIM_W'(1));
			sum_s1.last_row  <= POS_W'(eff_h - DIM_W'(1));
		end
	end

endmodule

[rtl/mmbb_pad.sv]
// ----------------------------------------------------------------------------
// mmbb_pad
// Margin padding, edge clamping and the result register.
// ----------------------------------------------------------------------------
module mmbb_pad (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sum_valid_s1,
	input  mmbb_pkg::summary_t sum_s1,
	output logic               sum_ready,
	mmbb_res_if.source         res
);
	import mmbb_pkg::*;

	logic found;
	dim_t mrg_ext, right_sum, bottom_sum;
	pos_t left, top, right, bottom;

	assign found      = sum_s1.count != '0;
	assign mrg_ext    = DIM_W'(sum_s1.margin);
	assign right_sum  = {1'b0, sum_s1.great_col} + mrg_ext;
	assign bottom_sum = {1'b0, sum_s1.great_row} + mrg_ext;

	always_comb begin
		left   = '0;
		top    = '0;
		right  = '0;
		bottom = '0;
		if (found) begin
			if (sum_s1.least_col > mrg_ext) begin
				left = POS_W'(sum_s1.least_col - mrg_ext);
			end
			if (sum_s1.least_row > mrg_ext) begin
				top = POS_W'(sum_s1.least_row - mrg_ext);
			end
			right  = (right_sum > {1'b0, sum_s1.last_col}) ?
				sum_s1.last_col : right_sum[POS_W-1:0];
			bottom = (bottom_sum > {1'b0, sum_s1.last_row}) ?
				sum_s1.last_row : bottom_sum[POS_W-1:0];
		end
	end

	assign sum_ready = !res.valid || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (sum_ready) begin
			res.valid <= sum_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (sum_ready && sum_valid_s1) begin
			res.change_count <= sum_s1.count;
			res.motion_found <= found;
			res.box_left     <= left;
			res.box_top      <= top;
			res.box_right    <= right;
			res.box_bottom   <= bottom;
		end
	end

endmodule

[tb/mmbb_checker.sv]
// ----------------------------------------------------------------------------
// mmbb_checker
// Watches the pixel, result and register channels of the mask bounding-box
// block. It keeps its own copy of the sizes, positions, hit count and box,
// and queues one frame report for every frame_end beat. Each result beat is
// compared field by field with the oldest report in the queue.
// ----------------------------------------------------------------------------
module mmbb_checker (
	input  logic clk,
	input  logic arst_n,
	mmbb_pix_if  pix,
	mmbb_res_if  res,
	mmbb_cfg_if  cfg,
	output int   fails,
	output int   pending,
	output int   reports
);
	import mmbb_pkg::*;

	localparam int MAX_SHOWN = 10;

	typedef struct packed {
		cnt_t count;
		logic found;
		pos_t left;
		pos_t top;
		pos_t right;
		pos_t bottom;
	} frame_report_t;

	frame_report_t reports_due[$];

	dim_t width_reg;
	dim_t height_reg;
	mrg_t margin_reg;

	int   col_at;
	int   row_at;
	cnt_t hits;
	dim_t low_col;
	pos_t high_col;
	dim_t low_row;
	pos_t high_row;

	function automatic int usable_size(input dim_t v);
		if (v == '0) begin
			return 1;
		end
		if (v > MAX_DIMENSION) begin
			return MAX_DIMENSION;
		end
		return int'(v);
	endfunction

	task automatic restart_frame();
		col_at   = 0;
		row_at   = 0;
		hits     = '0;
		low_col  = dim_t'(usable_size(width_reg));
		high_col = '0;
		low_row  = dim_t'(usable_size(height_reg));
		high_row = '0;
	endtask

	task automatic take_pixel(input pix_t v, input logic last);
		int w, h, lft, tp, rgt, bot;
		frame_report_t rpt;
		w = usable_size(width_reg);
		h = usable_size(height_reg);
		if (col_at % SAMPLE_STRIDE == 0 && row_at % SAMPLE_STRIDE == 0 &&
				v == MOTION_LEVEL) begin
			if (hits != COUNT_MAX) begin
				hits = hits + 1'b1;
			end
			if (col_at < int'(low_col)) begin
				low_col = dim_t'(col_at);
			end
			if (col_at > int'(high_col)) begin
				high_col = pos_t'(col_at);
			end
			if (row_at < int'(low_row)) begin
				low_row = dim_t'(row_at);
			end
			if (row_at > int'(high_row)) begin
				high_row = pos_t'(row_at);
			end
		end
		if (last) begin
			rpt = '0;
			rpt.count = hits;
			rpt.found = (hits != '0);
			if (rpt.found) begin
				lft = int'(low_col) - int'(margin_reg);
				tp  = int'(low_row) - int'(margin_reg);
				rgt = int'(high_col) + int'(margin_reg);
				bot = int'(high_row) + int'(margin_reg);
				if (lft < 0) begin
					lft = 0;
				end
				if (tp < 0) begin
					tp = 0;
				end
				if (rgt > w - 1) begin
					rgt = w - 1;
				end
				if (bot > h - 1) begin
					bot = h - 1;
				end
				rpt.left   = pos_t'(lft);
				rpt.top    = pos_t'(tp);
				rpt.right  = pos_t'(rgt);
				rpt.bottom = pos_t'(bot);
			end
			reports_due.push_back(rpt);
			restart_frame();
		end else if (col_at + 1 >= w) begin
			col_at = 0;
			row_at = (row_at + 1 >= h) ? 0 : (row_at + 1) % (1 << POS_W);
		end else begin
			col_at = (col_at + 1) % (1 << POS_W);
		end
	endtask

	task automatic apply_write(input logic [IDX_W-1:0] idx, input dim_t data);
		case (idx)
			REG_FRAME_WIDTH: width_reg = data;
			REG_FRAME_HEIGHT: height_reg = data;
			REG_BOX_MARGIN: margin_reg = data[MRG_W-1:0];
			default: ;
		endcase
	endtask

	task automatic flag(input string what, input frame_report_t want,
			input frame_report_t got);
		fails++;
		if (fails <= MAX_SHOWN) begin
			$display("%s: expected count %0d found %0b box %0d %0d %0d %0d", what,
				want.count, want.found, want.left, want.top, want.right, want.bottom);
			$display("    got count %0d found %0b box %0d %0d %0d %0d",
				got.count, got.found, got.left, got.top, got.right, got.bottom);
		end
	endtask

	task automatic check_report();
		frame_report_t want, got;
		got.count  = res.change_count;
		got.found  = res.motion_found;
		got.left   = res.box_left;
		got.top    = res.box_top;
		got.right  = res.box_right;
		got.bottom = res.box_bottom;
		reports++;
		if (reports_due.size() == 0) begin
			flag("frame report with no frame outstanding", '0, got);
		end else begin
			want = reports_due.pop_front();
			if (got !== want) begin
				flag("frame report mismatch", want, got);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg  = RST_FRAME_WIDTH;
			height_reg = RST_FRAME_HEIGHT;
			margin_reg = RST_BOX_MARGIN;
			restart_frame();
			reports_due.delete();
			fails   = 0;
			reports = 0;
		end else begin
			if (pix.valid && pix.ready) begin
				take_pixel(pix.mask_value, pix.frame_end);
			end
			if (cfg.valid && cfg.ready) begin
				apply_write(cfg.index, cfg.data);
			end
			if (res.valid && res.ready) begin
				check_report();
			end
		end
		pending = reports_due.size();
	end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives mask pixel frames and register writes into the bounding-box block,
// with random gaps on the pixel side and random stalls on the result side.
// A short directed run covers sizes, margins and frame-end cases; random
// phases follow under changing settings, one of them with a long output stall.
// ----------------------------------------------------------------------------
module tb;
	import mmbb_pkg::*;

	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 2000;
	localparam int PHASE_COUNT  = 12;
	localparam int PHASE_PIXELS = 94;
	localparam int FRAME_CAP    = 160;
	localparam int SETTLE_WAIT  = 4;
	localparam int TAIL_CYCLES  = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mmbb_pix_if pix ();
	mmbb_res_if res ();
	mmbb_cfg_if cfg ();

	int fails;
	int pending;
	int reports;
	int pixels_sent = 0;
	int settings_used = 0;
	int quiet_cycles = 0;
	bit idle_on = 1'b1;
	bit long_hold = 1'b0;

	motion_mask_bounding_box uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix),
		.res_out (res),
		.cfg     (cfg)
	);

	mmbb_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix     (pix),
		.res     (res),
		.cfg     (cfg),
		.fails   (fails),
		.pending (pending),
		.reports (reports)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (pix.valid && pix.ready) || (res.valid && res.ready) ||
				(cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("no beat for %0d cycles", quiet_cycles);
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic int draw_gap();
		if (!idle_on || $urandom_range(0, 1) == 0) begin
			return 0;
		end
		return $urandom_range(1, 16);
	endfunction

	function automatic pix_t draw_mask();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return MOTION_LEVEL;
			4, 5, 6: return '0;
			default: return pix_t'($urandom);
		endcase
	endfunction

	function automatic int frame_length(input dim_t w, input dim_t h);
		int fw, fh, n, lim;
		fw = (w == '0) ? 1 : ((w > MAX_DIMENSION) ? MAX_DIMENSION : int'(w));
		fh = (h == '0) ? 1 : ((h > MAX_DIMENSION) ? MAX_DIMENSION : int'(h));
		n = fw * fh;
		if (n > FRAME_CAP) begin
			n = $urandom_range(1, FRAME_CAP);
		end
		lim = (2 * fw < 16) ? 2 * fw : 16;
		case ($urandom_range(0, 9))
			0, 1: n = $urandom_range(1, n);
			2: n = n + $urandom_range(1, lim);
			default: ;
		endcase
		return n;
	endfunction

	task automatic push_pixel(input pix_t v, input logic last);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid      <= 1'b1;
		pix.mask_value <= v;
		pix.frame_end  <= last;
		do @(posedge clk); while (!pix.ready);
		pixels_sent++;
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input dim_t data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic configure(input dim_t w, input dim_t h, input dim_t m);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_BOX_MARGIN, m);
		if ($urandom_range(0, 3) == 0) begin
			write_reg(REG_SPARE, dim_t'($urandom));
		end
		cfg.valid <= 1'b0;
		settings_used++;
	endtask

	task automatic settle();
		pix.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	initial begin : drain
		int wait_n;
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				wait_n = HOLD_CYCLES;
				long_hold = 1'b0;
			end else begin
				wait_n = draw_gap();
			end
			if (wait_n > 0) begin
				res.ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid && !long_hold);
		end
	end

	initial begin : stimulus
		int n, len;
		dim_t w, h, m;
		pix.valid      <= 1'b0;
		pix.mask_value <= '0;
		pix.frame_end  <= 1'b0;
		cfg.valid      <= 1'b0;
		cfg.index      <= '0;
		cfg.data       <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// default sizes: two hits on row zero, then a frame with no hit
		push_pixel(MOTION_LEVEL, 1'b0);
		push_pixel(8'd0, 1'b0);
		push_pixel(MOTION_LEVEL, 1'b1);
		push_pixel(8'd254, 1'b0);
		push_pixel(8'd128, 1'b1);

		// full 3x3 frame: odd rows and columns drop out
		settle();
		configure(13'd3, 13'd3, 13'd0);
		for (n = 0; n < 9; n++) begin
			push_pixel(MOTION_LEVEL, n == 8);
		end

		// zero sizes act as one: every pixel wraps to the origin
		settle();
		configure(13'd0, 13'd0, 13'd255);
		push_pixel(MOTION_LEVEL, 1'b0);
		push_pixel(MOTION_LEVEL, 1'b0);
		push_pixel(8'd0, 1'b1);

		// oversized width clamps to the maximum
		settle();
		configure(13'd8191, 13'd2, 13'd255);
		push_pixel(MOTION_LEVEL, 1'b0);
		push_pixel(8'd0, 1'b0);
		push_pixel(MOTION_LEVEL, 1'b1);

		// shrink the width mid-frame, ignored index alongside
		settle();
		configure(13'd4, 13'd4, 13'd1);
		push_pixel(8'd0, 1'b0);
		push_pixel(8'd0, 1'b0);
		push_pixel(MOTION_LEVEL, 1'b0);
		settle();
		write_reg(REG_FRAME_WIDTH, 13'd2);
		write_reg(REG_SPARE, '1);
		cfg.valid <= 1'b0;
		push_pixel(8'd0, 1'b0);
		push_pixel(8'd0, 1'b0);
		push_pixel(8'd0, 1'b0);
		push_pixel(MOTION_LEVEL, 1'b1);

		for (int p = 0; p < PHASE_COUNT; p++) begin
			settle();
			case (p)
				0: begin
					w = 13'd1; h = 13'd1; m = 13'd0;
				end
				1: begin
					w = 13'd8191; h = 13'd2; m = 13'd255;
				end
				2: begin
					w = 13'd2; h = 13'd1; m = 13'd3;
				end
				3: begin
					w = 13'd4096; h = 13'd4096; m = 13'd255;
				end
				4: begin
					w = 13'd0; h = 13'd8191; m = 13'd0;
				end
				default: begin
					w = ($urandom_range(0, 5) == 0) ? dim_t'($urandom) :
						dim_t'($urandom_range(1, 12));
					h = ($urandom_range(0, 5) == 0) ? dim_t'($urandom) :
						dim_t'($urandom_range(1, 12));
					m = ($urandom_range(0, 1) == 0) ? dim_t'($urandom_range(0, 6)) :
						dim_t'($urandom);
				end
			endcase
			configure(w, h, m);
			idle_on = (p % 4 != 1);
			if (p == 2) begin
				long_hold = 1'b1;
			end
			n = 0;
			while (n < PHASE_PIXELS) begin
				len = frame_length(w, h);
				if (len > PHASE_PIXELS - n) begin
					len = PHASE_PIXELS - n;
				end
				for (int i = 0; i < len; i++) begin
					push_pixel(draw_mask(), i == len - 1);
				end
				n += len;
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		$display("%0d pixel beats under %0d register settings, %0d frame reports checked",
			pixels_sent, settings_used, reports);
		$display("sizes from zero to oversized, margins 0 to 255, ",
			"early and late frame ends, resize mid-frame, output held off");
		if (fails == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
